// ===== rtl/ptq_pkg.sv =====
// Shared types and constants for the priority task queue.
// No dependencies; used by every rtl file through scoped names.
package ptq_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int PRIORITY_WIDTH = 8;
    localparam int ID_W           = 4;
    localparam int IDX_W          = $clog2(QUEUE_DEPTH);
    localparam int CNT_W          = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_INS_PRIO = 3'd0,
        OP_INS_END  = 3'd1,
        OP_DEL_HEAD = 3'd2,
        OP_DEL_TASK = 3'd3,
        OP_PEEK     = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic                      write;
        logic [2:0]                op;
        logic [ID_W-1:0]           id;
        logic [PRIORITY_WIDTH-1:0] pr;
        logic [CNT_W-1:0]          count;
    } t_cell_ctl;

endpackage

// ===== rtl/ptq_cell.sv =====
// One queue slot: holds an entry, finds its own match, shifts left or right.
// Depends on ptq_pkg.
module ptq_cell (
    input  logic                               i_clk,
    input  ptq_pkg::t_cell_ctl                 i_ctl,
    input  logic [ptq_pkg::IDX_W-1:0]          i_index,
    input  logic [ptq_pkg::ID_W-1:0]           i_left_id,
    input  logic [ptq_pkg::PRIORITY_WIDTH-1:0] i_left_pr,
    input  logic [ptq_pkg::ID_W-1:0]           i_right_id,
    input  logic [ptq_pkg::PRIORITY_WIDTH-1:0] i_right_pr,
    input  logic                               i_found,
    input  logic [ptq_pkg::ID_W-1:0]           i_sel_id,
    input  logic [ptq_pkg::PRIORITY_WIDTH-1:0] i_sel_pr,
    output logic                               o_found,
    output logic [ptq_pkg::ID_W-1:0]           o_sel_id,
    output logic [ptq_pkg::PRIORITY_WIDTH-1:0] o_sel_pr,
    output logic [ptq_pkg::ID_W-1:0]           o_id,
    output logic [ptq_pkg::PRIORITY_WIDTH-1:0] o_pr
);

    logic [ptq_pkg::ID_W-1:0]           r_id;
    logic [ptq_pkg::PRIORITY_WIDTH-1:0] r_pr;
    logic [ptq_pkg::ID_W-1:0]           n_id;
    logic [ptq_pkg::PRIORITY_WIDTH-1:0] n_pr;
    logic                               occ;
    logic                               at_end;
    logic                               hit;
    logic                               first;
    logic                               load;

    assign occ    = ptq_pkg::CNT_W'(i_index) < i_ctl.count;
    assign at_end = ptq_pkg::CNT_W'(i_index) == i_ctl.count;
    assign first  = hit & ~i_found;

    always_comb begin
        case (i_ctl.op)
            ptq_pkg::OP_INS_PRIO: hit = occ & (i_ctl.pr < r_pr);
            ptq_pkg::OP_DEL_HEAD,
            ptq_pkg::OP_PEEK:     hit = occ & (i_index == '0);
            ptq_pkg::OP_DEL_TASK: hit = occ & (i_ctl.id == r_id);
            default:              hit = 1'b0;
        endcase
    end

    assign o_found  = i_found | hit;
    assign o_sel_id = first ? r_id : i_sel_id;
    assign o_sel_pr = first ? r_pr : i_sel_pr;

    always_comb begin
        load = 1'b0;
        n_id = r_id;
        n_pr = r_pr;
        case (i_ctl.op)
            ptq_pkg::OP_INS_PRIO,
            ptq_pkg::OP_INS_END: begin
                if (i_found) begin
                    // entries after the insertion point move one slot up
                    load = i_ctl.write;
                    n_id = i_left_id;
                    n_pr = i_left_pr;
                end else if (first || at_end) begin
                    load = i_ctl.write;
                    n_id = i_ctl.id;
                    n_pr = i_ctl.pr;
                end
            end
            ptq_pkg::OP_DEL_HEAD,
            ptq_pkg::OP_DEL_TASK: begin
                if (o_found) begin
                    load = i_ctl.write;
                    n_id = i_right_id;
                    n_pr = i_right_pr;
                end
            end
            default: load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_id <= n_id;
            r_pr <= n_pr;
        end
    end

    assign o_id = r_id;
    assign o_pr = r_pr;

endmodule

// ===== rtl/priority_task_queue_core.sv =====
// Priority task queue: a chain of ptq_cell slots with count and result register.
// Depends on ptq_pkg and ptq_cell.
// Output: result registered, valid the cycle after the input transfer.
// Throughput: one operation per cycle while o_in_stall is low; each finishes in
// a single pass through the cell chain (first-match ripple across the slots).
// Reset: synchronous active-low clears the entry count and output valid;
// slot contents are not cleared and are only read below the count.
module priority_task_queue_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [2:0]                         i_opcode,
    input  logic [ptq_pkg::ID_W-1:0]           i_task_id,
    input  logic [ptq_pkg::PRIORITY_WIDTH-1:0] i_priority_req,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [ptq_pkg::ID_W-1:0]           o_out_task_id,
    output logic [ptq_pkg::PRIORITY_WIDTH-1:0] o_out_priority,
    output logic [1:0]                         o_status,
    output logic [ptq_pkg::CNT_W-1:0]          o_length
);

    localparam int N = ptq_pkg::QUEUE_DEPTH;
    localparam int PW = ptq_pkg::PRIORITY_WIDTH;
    localparam int IW = ptq_pkg::ID_W;
    localparam int CW = ptq_pkg::CNT_W;

    logic                r_out_valid;
    logic [IW-1:0]       r_out_id;
    logic [PW-1:0]       r_out_pr;
    logic [1:0]          r_status;
    logic [CW-1:0]       r_length;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;

    logic                accept;
    logic                full;
    logic                empty;
    logic                write;
    logic [IW-1:0]       res_id;
    logic [PW-1:0]       res_pr;
    logic [1:0]          res_st;
    ptq_pkg::t_cell_ctl  ctl;

    logic [IW-1:0] cell_id  [N];
    logic [PW-1:0] cell_pr  [N];
    logic          found    [N+1];
    logic [IW-1:0] sel_id   [N+1];
    logic [PW-1:0] sel_pr   [N+1];

    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;
    assign full       = r_count == CW'(N);
    assign empty      = r_count == '0;

    assign ctl.write = accept & write;
    assign ctl.op    = i_opcode;
    assign ctl.id    = i_task_id;
    assign ctl.pr    = i_priority_req;
    assign ctl.count = r_count;

    assign found[0]  = 1'b0;
    assign sel_id[0] = '0;
    assign sel_pr[0] = '0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        logic [IW-1:0] left_id, right_id;
        logic [PW-1:0] left_pr, right_pr;
        if (g == 0) begin : g_first
            assign left_id = '0;
            assign left_pr = '0;
        end else begin : g_mid
            assign left_id = cell_id[g-1];
            assign left_pr = cell_pr[g-1];
        end
        if (g == N - 1) begin : g_last
            assign right_id = '0;
            assign right_pr = '0;
        end else begin : g_inner
            assign right_id = cell_id[g+1];
            assign right_pr = cell_pr[g+1];
        end
        ptq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_index    (ptq_pkg::IDX_W'(g)),
            .i_left_id  (left_id),
            .i_left_pr  (left_pr),
            .i_right_id (right_id),
            .i_right_pr (right_pr),
            .i_found    (found[g]),
            .i_sel_id   (sel_id[g]),
            .i_sel_pr   (sel_pr[g]),
            .o_found    (found[g+1]),
            .o_sel_id   (sel_id[g+1]),
            .o_sel_pr   (sel_pr[g+1]),
            .o_id       (cell_id[g]),
            .o_pr       (cell_pr[g])
        );
    end

    always_comb begin
        write   = 1'b0;
        res_id  = '0;
        res_pr  = '0;
        res_st  = ptq_pkg::ST_OK;
        n_count = r_count;
        case (ptq_pkg::t_opcode'(i_opcode))
            ptq_pkg::OP_INS_PRIO,
            ptq_pkg::OP_INS_END: begin
                if (full) begin
                    res_st = ptq_pkg::ST_FULL;
                end else begin
                    write   = 1'b1;
                    res_id  = i_task_id;
                    res_pr  = i_priority_req;
                    n_count = r_count + CW'(1);
                end
            end
            ptq_pkg::OP_DEL_HEAD,
            ptq_pkg::OP_PEEK,
            ptq_pkg::OP_DEL_TASK: begin
                if (empty) begin
                    res_st = ptq_pkg::ST_EMPTY;
                end else if (!found[N]) begin
                    res_st = ptq_pkg::ST_NOT_FOUND;
                end else begin
                    res_id = sel_id[N];
                    res_pr = sel_pr[N];
                    if (i_opcode != ptq_pkg::OP_PEEK) begin
                        write   = 1'b1;
                        n_count = r_count - CW'(1);
                    end
                end
            end
            default: write = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_id <= res_id;
            r_out_pr <= res_pr;
            r_status <= res_st;
            r_length <= n_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_task_id  = r_out_id;
    assign o_out_priority = r_out_pr;
    assign o_status       = r_status;
    assign o_length       = r_length;

endmodule

// ===== rtl/ptq_checker.sv =====
// Port-level checks for priority_task_queue_core, attached by bind.
// Depends on ptq_pkg.
module ptq_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic [ptq_pkg::ID_W-1:0]           o_out_task_id,
    input logic [ptq_pkg::PRIORITY_WIDTH-1:0] o_out_priority,
    input logic [1:0]                         o_status,
    input logic [ptq_pkg::CNT_W-1:0]          o_length
);

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_length <= ptq_pkg::CNT_W'(ptq_pkg::QUEUE_DEPTH))
        else $error("length beyond depth");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ptq_pkg::ST_FULL)
        |-> o_length == ptq_pkg::CNT_W'(ptq_pkg::QUEUE_DEPTH))
        else $error("full status with room left");

    a_empty_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ptq_pkg::ST_EMPTY)
        |-> (o_length == '0 && o_out_task_id == '0 && o_out_priority == '0))
        else $error("empty status with data");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_status)
        && $stable(o_length) && $stable(o_out_task_id)))
        else $error("stalled result changed");

    // every input transfer shows up as a result on the next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("input transfer without result");

endmodule

bind priority_task_queue_core ptq_checker u_ptq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_out_task_id  (o_out_task_id),
    .o_out_priority (o_out_priority),
    .o_status       (o_status),
    .o_length       (o_length)
);

// ===== tb/priority_task_queue_core_tb.sv =====
// Self-checking testbench for priority_task_queue_core: a behavioral queue predicts
// every result, with random idle and output stall bursts. Depends on ptq_pkg and the RTL.
`timescale 1ns / 1ps

module priority_task_queue_core_tb;

    localparam int          PW          = ptq_pkg::PRIORITY_WIDTH;
    localparam int          IW          = ptq_pkg::ID_W;
    localparam int          CW          = ptq_pkg::CNT_W;
    localparam int          DEPTH       = ptq_pkg::QUEUE_DEPTH;
    localparam logic [2:0]  OP_NOP_LO   = 3'd5;
    localparam logic [2:0]  OP_NOP_HI   = 3'd7;
    localparam int          RAND_ITEMS  = 1500;
    localparam int          QUIET_ITEMS = 200;

    typedef struct {
        logic [IW-1:0]     id;
        logic [PW-1:0]     pr;
        ptq_pkg::t_status  status;
        logic [CW-1:0]     length;
    } t_queue_result;

    logic             clk            = 1'b0;
    logic             rst_n          = 1'b0;
    logic             in_valid       = 1'b0;
    logic [2:0]       in_opcode      = '0;
    logic [IW-1:0]    in_task_id     = '0;
    logic [PW-1:0]    in_priority    = '0;
    logic             out_stall      = 1'b0;
    logic             o_in_stall;
    logic             o_out_valid;
    logic [IW-1:0]    o_out_task_id;
    logic [PW-1:0]    o_out_priority;
    logic [1:0]       o_status;
    logic [CW-1:0]    o_length;

    // Behavioral copy of the queue, in list order.
    logic [IW-1:0]    sched_ids   [DEPTH];
    logic [PW-1:0]    sched_prios [DEPTH];
    int               sched_count = 0;

    t_queue_result    pending_results[$];
    t_queue_result    head_result;
    int               errors      = 0;
    bit               idle_en     = 1'b1;
    int               stall_left  = 0;

    priority_task_queue_core i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (in_opcode),
        .i_task_id      (in_task_id),
        .i_priority_req (in_priority),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_out_task_id  (o_out_task_id),
        .o_out_priority (o_out_priority),
        .o_status       (o_status),
        .o_length       (o_length)
    );

    always #2 clk = ~clk;

    // Apply one operation to the behavioral queue and return what the block must report.
    function automatic t_queue_result sched_apply(logic [2:0] op, logic [IW-1:0] id,
                                                  logic [PW-1:0] pr);
        t_queue_result r;
        int pos;
        r.id     = '0;
        r.pr     = '0;
        r.status = ptq_pkg::ST_OK;
        case (op)
            ptq_pkg::OP_INS_PRIO, ptq_pkg::OP_INS_END: begin
                if (sched_count >= DEPTH) begin
                    r.status = ptq_pkg::ST_FULL;
                end else begin
                    pos = 0;
                    if (op == ptq_pkg::OP_INS_PRIO) begin
                        while (pos < sched_count && pr >= sched_prios[pos]) pos++;
                    end else begin
                        pos = sched_count;
                    end
                    for (int i = sched_count; i > pos; i--) begin
                        sched_ids[i]   = sched_ids[i-1];
                        sched_prios[i] = sched_prios[i-1];
                    end
                    sched_ids[pos]   = id;
                    sched_prios[pos] = pr;
                    sched_count++;
                    r.id = id;
                    r.pr = pr;
                end
            end
            ptq_pkg::OP_DEL_HEAD, ptq_pkg::OP_PEEK, ptq_pkg::OP_DEL_TASK: begin
                if (sched_count == 0) begin
                    r.status = ptq_pkg::ST_EMPTY;
                end else begin
                    pos = 0;
                    if (op == ptq_pkg::OP_DEL_TASK) begin
                        while (pos < sched_count && sched_ids[pos] != id) pos++;
                    end
                    if (pos >= sched_count) begin
                        r.status = ptq_pkg::ST_NOT_FOUND;
                    end else begin
                        r.id = sched_ids[pos];
                        r.pr = sched_prios[pos];
                        if (op != ptq_pkg::OP_PEEK) begin
                            for (int i = pos; i + 1 < sched_count; i++) begin
                                sched_ids[i]   = sched_ids[i+1];
                                sched_prios[i] = sched_prios[i+1];
                            end
                            sched_count--;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.length = CW'(sched_count);
        return r;
    endfunction

    // One input transfer, with an optional idle burst ahead of it.
    task automatic send_op(logic [2:0] op, logic [IW-1:0] id, logic [PW-1:0] pr);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_opcode   <= op;
        in_task_id  <= id;
        in_priority <= pr;
        do @(posedge clk); while (o_in_stall);
        pending_results.insert(pending_results.size(), sched_apply(op, id, pr));
    endtask

    // Output side stall bursts.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 4);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Result checker: every transfer is matched against the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && o_out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result id=%0d pr=%0d st=%0d len=%0d", $time,
                         o_out_task_id, o_out_priority, o_status, o_length);
            end else begin
                head_result = pending_results.pop_front();
                if (o_out_task_id !== head_result.id || o_out_priority !== head_result.pr ||
                    o_status !== head_result.status || o_length !== head_result.length) begin
                    errors++;
                    $display("%0t: mismatch expected id=%0d pr=%0d st=%0d len=%0d",
                             $time, head_result.id, head_result.pr, head_result.status,
                             head_result.length);
                    $display("%0t:          actual   id=%0d pr=%0d st=%0d len=%0d",
                             $time, o_out_task_id, o_out_priority, o_status, o_length);
                end
            end
        end
    end

    task automatic test_empty_queue();
        send_op(ptq_pkg::OP_PEEK, 4'd3, 8'd9);
        send_op(ptq_pkg::OP_DEL_HEAD, 4'd0, 8'd0);
        send_op(ptq_pkg::OP_DEL_TASK, 4'd15, 8'd255);
    endtask

    task automatic test_ordering();
        send_op(ptq_pkg::OP_INS_PRIO, 4'd15, 8'd255);
        send_op(ptq_pkg::OP_INS_PRIO, 4'd0, 8'd0);
        send_op(ptq_pkg::OP_INS_PRIO, 4'd5, 8'd100);
        send_op(ptq_pkg::OP_INS_PRIO, 4'd6, 8'd100);   // ties stay FIFO
        send_op(ptq_pkg::OP_INS_END, 4'd5, 8'd1);      // duplicate id, appended unordered
        send_op(ptq_pkg::OP_PEEK, 4'd0, 8'd0);
        send_op(ptq_pkg::OP_DEL_TASK, 4'd9, 8'd0);     // no such id
        send_op(ptq_pkg::OP_DEL_TASK, 4'd5, 8'd0);     // first match only
        send_op(OP_NOP_LO, 4'd15, 8'd255);
        send_op(OP_NOP_LO + 3'd1, 4'd1, 8'd1);
        send_op(OP_NOP_HI, 4'd2, 8'd2);
        repeat (5) send_op(ptq_pkg::OP_DEL_HEAD, 4'd0, 8'd0);
    endtask

    task automatic test_full_queue();
        for (int i = 0; i < DEPTH; i++)
            send_op($urandom_range(0, 1) ? ptq_pkg::OP_INS_PRIO : ptq_pkg::OP_INS_END,
                    IW'(i), PW'($urandom_range(0, 255)));
        send_op(ptq_pkg::OP_INS_PRIO, 4'd7, 8'd7);
        send_op(ptq_pkg::OP_INS_END, 4'd8, 8'd8);
        send_op(ptq_pkg::OP_PEEK, 4'd0, 8'd0);
    endtask

    // Random mix that walks the length toward a moving target, hitting full and empty.
    task automatic test_random_mix(int n_items);
        int          target;
        int          r;
        bit          grow;
        logic [2:0]  op;
        logic [IW-1:0] id;
        logic [PW-1:0] pr;
        target = 0;
        for (int n = 0; n < n_items; n++) begin
            if (n % 50 == 0) begin
                case ($urandom_range(0, 3))
                    0: target = 0;
                    1: target = DEPTH;
                    default: target = $urandom_range(0, DEPTH);
                endcase
            end
            if (n_items > QUIET_ITEMS && n % 120 == 0) idle_en = ($urandom_range(0, 3) != 0);
            grow = (sched_count < target) || (target == DEPTH);
            r    = $urandom_range(0, 99);
            id   = IW'($urandom_range(0, 15));
            pr   = $urandom_range(0, 1) ? PW'($urandom_range(0, 7)) : PW'($urandom_range(0, 255));
            if (r < 4) begin
                op = 3'($urandom_range(OP_NOP_LO, OP_NOP_HI));
            end else if (r < 12) begin
                op = ptq_pkg::OP_PEEK;
            end else if ((grow && r < 72) || (!grow && r < 30)) begin
                op = ($urandom_range(0, 9) < 7) ? ptq_pkg::OP_INS_PRIO : ptq_pkg::OP_INS_END;
            end else if ($urandom_range(0, 1)) begin
                op = ptq_pkg::OP_DEL_HEAD;
            end else begin
                op = ptq_pkg::OP_DEL_TASK;
                if (sched_count > 0 && $urandom_range(0, 3) != 0)
                    id = sched_ids[$urandom_range(0, sched_count - 1)];
            end
            send_op(op, id, pr);
        end
    endtask

    task automatic test_back_to_back();
        idle_en = 1'b0;
        test_random_mix(QUIET_ITEMS);
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_queue();
        test_ordering();
        test_full_queue();
        test_random_mix(RAND_ITEMS);
        test_back_to_back();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== priority_task_queue_core.f =====
rtl/ptq_pkg.sv
rtl/ptq_cell.sv
rtl/priority_task_queue_core.sv
rtl/ptq_checker.sv
tb/priority_task_queue_core_tb.sv
